// ----- sv/yuyv2bgr_pkg.sv -----
package yuyv2bgr_pkg;

  // Q16 chroma coefficients (coefficient * 65536, truncated)
  localparam int unsigned KqRv = 91881;
  localparam int unsigned KqGv = 46792;
  localparam int unsigned KqGu = 21889;
  localparam int unsigned KqBu = 116129;

  localparam int unsigned QShift   = 16;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CoefW    = 17;
  localparam int unsigned ChromaW  = 9;
  localparam int unsigned ProdW    = CoefW + 1 + ChromaW;
  localparam int unsigned DeltaW   = 9;
  localparam int unsigned SumW     = 10;

  localparam logic [PixW-1:0] PixMax     = 8'd255;
  localparam logic [PixW-1:0] AlphaValue = 8'd255;

  // chroma correction terms shared by both pixels of a macropixel
  typedef struct packed {
    logic signed [DeltaW-1:0] dr;
    logic signed [DeltaW-1:0] dg;
    logic signed [DeltaW-1:0] db;
  } delta_t;

  // saturate a signed sum into 0..255
  function automatic logic [PixW-1:0] clamp_pix(input logic signed [SumW-1:0] s);
    logic [PixW-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (s > $signed({2'b00, PixMax})) begin
      r = PixMax;
    end else begin
      r = s[PixW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/yuyv_to_bgr_converter_core.sv -----
// YUYV to BGR(A) converter: one YUYV macropixel in, two BT.601 pixels out per word,
// one word per clock while the output is not stalled. Each word passes an input
// register, then the chroma multiplies, luma add and 0..255 clamp, then the
// result register. The input stalls only while both registers hold a word and
// the output is stalled. The with_alpha register (write via
// cfg_valid_i/cfg_ready_o) drives alpha_byte_o to 255 when set and 0
// otherwise; write it only while idle.
module yuyv_to_bgr_converter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_with_alpha_i,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] luma_first_i,
  input  logic [7:0] chroma_u_i,
  input  logic [7:0] luma_second_i,
  input  logic [7:0] chroma_v_i,
  input  logic       frame_end_in_i,
  // result words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] blue_first_o,
  output logic [7:0] green_first_o,
  output logic [7:0] red_first_o,
  output logic [7:0] blue_second_o,
  output logic [7:0] green_second_o,
  output logic [7:0] red_second_o,
  output logic [7:0] alpha_byte_o,
  output logic       frame_end_out_o
);

  logic       with_alpha_q;
  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept, s2_load;

  logic [7:0] y0_q, u_q, y1_q, v_q;
  logic       fe_q;

  yuyv2bgr_pkg::delta_t delta;
  logic [7:0] b0, g0, r0, b1, g1, r1;

  logic [7:0] b0_q, g0_q, r0_q, b1_q, g1_q, r1_q, alpha_q;
  logic       fe_out_q;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      with_alpha_q <= 1'b0;
    end else if (cfg_valid_i) begin
      with_alpha_q <= cfg_with_alpha_i;
    end
  end

  // pipeline flow control
  assign s2_load    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign s1_valid_d  = in_accept | (s1_valid_q & ~s2_load);
  assign out_valid_d = s2_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      y0_q <= luma_first_i;
      u_q  <= chroma_u_i;
      y1_q <= luma_second_i;
      v_q  <= chroma_v_i;
      fe_q <= frame_end_in_i;
    end
  end

  // conversion datapath
  yuyv2bgr_chroma u_chroma (
    .chroma_u_i (u_q),
    .chroma_v_i (v_q),
    .delta_o    (delta)
  );

  yuyv2bgr_pixel u_pix_first (
    .luma_i  (y0_q),
    .delta_i (delta),
    .blue_o  (b0),
    .green_o (g0),
    .red_o   (r0)
  );

  yuyv2bgr_pixel u_pix_second (
    .luma_i  (y1_q),
    .delta_i (delta),
    .blue_o  (b1),
    .green_o (g1),
    .red_o   (r1)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      b0_q     <= b0;
      g0_q     <= g0;
      r0_q     <= r0;
      b1_q     <= b1;
      g1_q     <= g1;
      r1_q     <= r1;
      alpha_q  <= with_alpha_q ? yuyv2bgr_pkg::AlphaValue : '0;
      fe_out_q <= fe_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blue_first_o    = b0_q;
  assign green_first_o   = g0_q;
  assign red_first_o     = r0_q;
  assign blue_second_o   = b1_q;
  assign green_second_o  = g1_q;
  assign red_second_o    = r1_q;
  assign alpha_byte_o    = alpha_q;
  assign frame_end_out_o = fe_out_q;

endmodule

// ----- sv/yuyv2bgr_chroma.sv -----
module yuyv2bgr_chroma (
  input  logic [7:0]             chroma_u_i,
  input  logic [7:0]             chroma_v_i,
  output yuyv2bgr_pkg::delta_t   delta_o
);

  logic signed [yuyv2bgr_pkg::ChromaW-1:0] u_s;
  logic signed [yuyv2bgr_pkg::ChromaW-1:0] v_s;
  logic signed [yuyv2bgr_pkg::ProdW-1:0]   p_rv;
  logic signed [yuyv2bgr_pkg::ProdW-1:0]   p_gv;
  logic signed [yuyv2bgr_pkg::ProdW-1:0]   p_gu;
  logic signed [yuyv2bgr_pkg::ProdW-1:0]   p_bu;
  logic signed [yuyv2bgr_pkg::DeltaW-1:0]  t_gv;
  logic signed [yuyv2bgr_pkg::DeltaW-1:0]  t_gu;

  // remove the 128 offset: flipping the MSB gives two's complement
  assign u_s = $signed({~chroma_u_i[7], ~chroma_u_i[7], chroma_u_i[6:0]});
  assign v_s = $signed({~chroma_v_i[7], ~chroma_v_i[7], chroma_v_i[6:0]});

  // constant multiplies
  assign p_rv = $signed({1'b0, yuyv2bgr_pkg::CoefW'(yuyv2bgr_pkg::KqRv)}) * v_s;
  assign p_gv = $signed({1'b0, yuyv2bgr_pkg::CoefW'(yuyv2bgr_pkg::KqGv)}) * v_s;
  assign p_gu = $signed({1'b0, yuyv2bgr_pkg::CoefW'(yuyv2bgr_pkg::KqGu)}) * u_s;
  assign p_bu = $signed({1'b0, yuyv2bgr_pkg::CoefW'(yuyv2bgr_pkg::KqBu)}) * u_s;

  // arithmetic shift by 16 (floor); results fit in 9 signed bits
  assign t_gv = p_gv[yuyv2bgr_pkg::QShift +: yuyv2bgr_pkg::DeltaW];
  assign t_gu = p_gu[yuyv2bgr_pkg::QShift +: yuyv2bgr_pkg::DeltaW];

  assign delta_o.dr = p_rv[yuyv2bgr_pkg::QShift +: yuyv2bgr_pkg::DeltaW];
  assign delta_o.db = p_bu[yuyv2bgr_pkg::QShift +: yuyv2bgr_pkg::DeltaW];
  // green term stays within -135..132
  assign delta_o.dg = t_gv + t_gu;

endmodule

// ----- sv/yuyv2bgr_pixel.sv -----
module yuyv2bgr_pixel (
  input  logic [7:0]           luma_i,
  input  yuyv2bgr_pkg::delta_t delta_i,
  output logic [7:0]           blue_o,
  output logic [7:0]           green_o,
  output logic [7:0]           red_o
);

  logic signed [yuyv2bgr_pkg::SumW-1:0] y_s;
  logic signed [yuyv2bgr_pkg::SumW-1:0] b_sum;
  logic signed [yuyv2bgr_pkg::SumW-1:0] g_sum;
  logic signed [yuyv2bgr_pkg::SumW-1:0] r_sum;

  assign y_s = $signed({2'b00, luma_i});

  // luma plus the blue and red terms, minus the green term, sign-extended to the sum width
  assign b_sum = y_s + $signed({delta_i.db[yuyv2bgr_pkg::DeltaW-1], delta_i.db});
  assign g_sum = y_s - $signed({delta_i.dg[yuyv2bgr_pkg::DeltaW-1], delta_i.dg});
  assign r_sum = y_s + $signed({delta_i.dr[yuyv2bgr_pkg::DeltaW-1], delta_i.dr});

  assign blue_o  = yuyv2bgr_pkg::clamp_pix(b_sum);
  assign green_o = yuyv2bgr_pkg::clamp_pix(g_sum);
  assign red_o   = yuyv2bgr_pkg::clamp_pix(r_sum);

endmodule

// ----- tb/sv/yuyv_to_bgr_checker.sv -----
`timescale 1ns / 1ps

// Watches both word channels and the mode write port, predicts every result
// word from the accepted macropixels and compares them in order.
module yuyv_to_bgr_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  // mode write port
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_with_alpha_i,
  // input words
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] luma_first_i,
  input  logic [7:0] chroma_u_i,
  input  logic [7:0] luma_second_i,
  input  logic [7:0] chroma_v_i,
  input  logic       frame_end_in_i,
  // result words
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] blue_first_i,
  input  logic [7:0] green_first_i,
  input  logic [7:0] red_first_i,
  input  logic [7:0] blue_second_i,
  input  logic [7:0] green_second_i,
  input  logic [7:0] red_second_i,
  input  logic [7:0] alpha_byte_i,
  input  logic       frame_end_out_i,
  // status for the test top
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic [7:0] alpha;
    logic       frame_end;
  } bgr_word_t;

  bgr_word_t expected_words[$];
  bgr_word_t oldest;
  logic      alpha_mode;

  // saturate a signed sum into one pixel byte
  function automatic logic [7:0] saturate_pix(input int sum);
    logic [7:0] pix;
    if (sum < 0) begin
      pix = '0;
    end else if (sum > int'(yuyv2bgr_pkg::PixMax)) begin
      pix = yuyv2bgr_pkg::PixMax;
    end else begin
      pix = sum[7:0];
    end
    return pix;
  endfunction

  // BT.601 conversion in Q16; >>> on a signed int rounds toward minus infinity
  function automatic bgr_word_t convert_macropixel(
    input logic [7:0] y0,
    input logic [7:0] u_byte,
    input logic [7:0] y1,
    input logic [7:0] v_byte,
    input logic       frame_end,
    input logic       with_alpha
  );
    bgr_word_t w;
    int        u;
    int        v;
    int        k_rv;
    int        k_gv;
    int        k_gu;
    int        k_bu;
    int        d_red;
    int        d_green;
    int        d_blue;
    k_rv    = yuyv2bgr_pkg::KqRv;
    k_gv    = yuyv2bgr_pkg::KqGv;
    k_gu    = yuyv2bgr_pkg::KqGu;
    k_bu    = yuyv2bgr_pkg::KqBu;
    u       = int'(u_byte) - 128;
    v       = int'(v_byte) - 128;
    d_red   = (k_rv * v) >>> yuyv2bgr_pkg::QShift;
    d_green = ((k_gv * v) >>> yuyv2bgr_pkg::QShift) + ((k_gu * u) >>> yuyv2bgr_pkg::QShift);
    d_blue  = (k_bu * u) >>> yuyv2bgr_pkg::QShift;
    w.blue_first   = saturate_pix(int'(y0) + d_blue);
    w.green_first  = saturate_pix(int'(y0) - d_green);
    w.red_first    = saturate_pix(int'(y0) + d_red);
    w.blue_second  = saturate_pix(int'(y1) + d_blue);
    w.green_second = saturate_pix(int'(y1) - d_green);
    w.red_second   = saturate_pix(int'(y1) + d_red);
    w.alpha        = with_alpha ? yuyv2bgr_pkg::AlphaValue : 8'd0;
    w.frame_end    = frame_end;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      alpha_mode   = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_words.push_back(convert_macropixel(luma_first_i, chroma_u_i, luma_second_i,
                                                    chroma_v_i, frame_end_in_i, alpha_mode));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with no macropixel pending");
          fail_count_o++;
        end else begin
          oldest = expected_words.pop_front();
          check_field("blue_first", oldest.blue_first, blue_first_i);
          check_field("green_first", oldest.green_first, green_first_i);
          check_field("red_first", oldest.red_first, red_first_i);
          check_field("blue_second", oldest.blue_second, blue_second_i);
          check_field("green_second", oldest.green_second, green_second_i);
          check_field("red_second", oldest.red_second, red_second_i);
          check_field("alpha_byte", oldest.alpha, alpha_byte_i);
          check_field("frame_end_out", {7'd0, oldest.frame_end}, {7'd0, frame_end_out_i});
          checked_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        alpha_mode = cfg_with_alpha_i;
      end
      pending_o = expected_words.size();
    end
  end

endmodule

// ----- tb/sv/tb_yuyv_to_bgr_converter_core.sv -----
`timescale 1ns / 1ps

module tb_yuyv_to_bgr_converter_core;

  localparam int PhaseWords = 260;

  logic       clk;
  logic       rst_n          = 1'b0;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic       cfg_with_alpha = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] luma_first     = '0;
  logic [7:0] chroma_u       = '0;
  logic [7:0] luma_second    = '0;
  logic [7:0] chroma_v       = '0;
  logic       frame_end_in   = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] blue_first;
  logic [7:0] green_first;
  logic [7:0] red_first;
  logic [7:0] blue_second;
  logic [7:0] green_second;
  logic [7:0] red_second;
  logic [7:0] alpha_byte;
  logic       frame_end_out;

  int         fail_count;
  int         pending;
  int         checked;
  int         words_sent;
  int         frame_marks;
  bit         steady = 1'b0;

  yuyv_to_bgr_converter_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_with_alpha_i (cfg_with_alpha),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .luma_first_i     (luma_first),
    .chroma_u_i       (chroma_u),
    .luma_second_i    (luma_second),
    .chroma_v_i       (chroma_v),
    .frame_end_in_i   (frame_end_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .blue_first_o     (blue_first),
    .green_first_o    (green_first),
    .red_first_o      (red_first),
    .blue_second_o    (blue_second),
    .green_second_o   (green_second),
    .red_second_o     (red_second),
    .alpha_byte_o     (alpha_byte),
    .frame_end_out_o  (frame_end_out)
  );

  yuyv_to_bgr_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_with_alpha_i (cfg_with_alpha),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .luma_first_i     (luma_first),
    .chroma_u_i       (chroma_u),
    .luma_second_i    (luma_second),
    .chroma_v_i       (chroma_v),
    .frame_end_in_i   (frame_end_in),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .blue_first_i     (blue_first),
    .green_first_i    (green_first),
    .red_first_i      (red_first),
    .blue_second_i    (blue_second),
    .green_second_i   (green_second),
    .red_second_i     (red_second),
    .alpha_byte_i     (alpha_byte),
    .frame_end_out_i  (frame_end_out),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // idle with a chance of 37 in 100, never while steady is set
  function automatic bit take_gap();
    return !steady && ($urandom_range(0, 99) < 37);
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= take_gap();
  end

  // offer one macropixel, return at the edge that accepts it
  task automatic push_macropixel(input logic [7:0] y0, input logic [7:0] u,
                                 input logic [7:0] y1, input logic [7:0] v,
                                 input logic fe);
    @(negedge clk);
    while (take_gap()) begin
      in_valid    <= 1'b0;
      luma_first  <= 8'($urandom);
      chroma_u    <= 8'($urandom);
      luma_second <= 8'($urandom);
      chroma_v    <= 8'($urandom);
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    luma_first   <= y0;
    chroma_u     <= u;
    luma_second  <= y1;
    chroma_v     <= v;
    frame_end_in <= fe;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (fe) frame_marks++;
  endtask

  // drop valid after a burst and wait until every result word is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mode write, only while drained
  task automatic write_mode(input logic with_alpha);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_with_alpha <= with_alpha;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mix of full-range, near-gray and saturating macropixels
  task automatic push_random_macropixel();
    logic [7:0] f[4];
    int         kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 4; i++) begin
      if (kind < 70) begin
        f[i] = 8'($urandom);
      end else if (kind < 85) begin
        f[i] = (i % 2 == 1) ? 8'($urandom_range(125, 131)) : 8'($urandom);
      end else begin
        case ($urandom_range(0, 2))
          0: f[i] = 8'd0;
          1: f[i] = 8'd255;
          default: f[i] = 8'($urandom);
        endcase
      end
    end
    push_macropixel(f[0], f[1], f[2], f[3], $urandom_range(0, 11) == 0);
  endtask

  initial begin
    words_sent  = 0;
    frame_marks = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, BGR mode out of reset
    push_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    push_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    push_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    push_macropixel(8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
    push_macropixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    push_macropixel(8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
    push_macropixel(8'd100, 8'd127, 8'd100, 8'd129, 1'b0);
    push_macropixel(8'd100, 8'd129, 8'd100, 8'd127, 1'b0);
    push_macropixel(8'd16, 8'd0, 8'd235, 8'd255, 1'b0);
    push_macropixel(8'd235, 8'd255, 8'd16, 8'd0, 1'b0);
    push_macropixel(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1);
    push_macropixel(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
    drain_results();

    // directed, BGRA mode
    write_mode(1'b1);
    push_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    push_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    push_macropixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0);
    push_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    push_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
    push_macropixel(8'd1, 8'd127, 8'd254, 8'd129, 1'b0);
    push_macropixel(8'd254, 8'd1, 8'd1, 8'd254, 1'b0);
    push_macropixel(8'd60, 8'd200, 8'd190, 8'd40, 1'b0);
    drain_results();

    // random phases, alternating the mode each time
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase % 2 == 1);
      for (int n = 0; n < PhaseWords; n++) begin
        steady = (phase == 2) && (n >= 40) && (n < 200);
        if (phase == 1 && n == PhaseWords / 2) begin
          drain_results();
        end
        push_random_macropixel();
      end
      steady = 1'b0;
      drain_results();
    end
    // rewrite the same value once
    write_mode(1'b1);
    push_random_macropixel();
    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d macropixels (%0d with frame end) through BGR and BGRA modes",
             words_sent, frame_marks);
    $display("Compared %0d result words, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/yuyv2bgr_pkg.sv
sv/yuyv2bgr_chroma.sv
sv/yuyv2bgr_pixel.sv
sv/yuyv_to_bgr_converter_core.sv
tb/sv/yuyv_to_bgr_checker.sv
tb/sv/tb_yuyv_to_bgr_converter_core.sv
